// ===== hdl/fprf_pkg.sv =====
// Package: shared constants, types and helpers for the false-position root finder.
`timescale 1ns / 1ps
package fprf_pkg;
    localparam int FRAC_BITS = 32;
    localparam int MAX_STEPS = 64;
    localparam int STEP_W = 7;
    localparam int COEF_W = 48;
    localparam int TOL_W = 33;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 48;

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0001;
    localparam logic [47:0] ROOT_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ROOT_MIN = 48'h8000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd3;

    localparam logic [47:0] COEF_SQUARE_RST = 48'h0001_0000_0000;
    localparam logic [47:0] COEF_LINEAR_RST = 48'hFFFB_0000_0000;
    localparam logic [47:0] COEF_CONST_RST = 48'h0006_0000_0000;
    localparam logic [32:0] TOLERANCE_RST = 33'd4295;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_STEP_LIMIT = 2'd2,
        ST_ZERO_DIV = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL_A1,
        S_EVAL_A2,
        S_EVAL_DONE,
        S_CHECK,
        S_NUM1,
        S_NUM2,
        S_DIV,
        S_DIV_WAIT,
        S_TEST,
        S_OUT
    } ctrl_state_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? SAT_MIN : SAT_MAX;
        end else if (s[63:0] == 64'h8000_0000_0000_0000) begin
            sat_add64 = SAT_MIN;
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // arithmetic shift of a 128-bit product by FRAC_BITS, saturated to +-(2^63-1)
    function automatic logic [63:0] sat_shift(input logic [127:0] p);
        logic [127:0] sh;
        sh = $signed(p) >>> FRAC_BITS;
        if (!sh[127]) begin
            sat_shift = (sh[127:63] == '0) ? sh[63:0] : SAT_MAX;
        end else begin
            sat_shift = (sh[127:63] == '1 && sh[62:0] != '0) ? sh[63:0] : SAT_MIN;
        end
    endfunction
endpackage

// ===== hdl/false_position_root_finder.sv =====
// Top level: false-position root finder for a configurable quadratic.
//
// Usage:
//   s_ channel carries one request: a bracket {upper_bound, lower_bound}.
//   m_ channel returns one result per request: {steps_used, status, root}.
//   Coefficients and tolerance are written on cfg_we/cfg_idx/cfg_data; the user must
//   do so only while idle, as the block itself does not enforce it.
//   All arithmetic runs on one bit-serial 64x64 multiplier and one bit-serial
//   128/64 divider. Each polynomial evaluation takes two products and the
//   S_EVAL_DONE state; each regula falsi step takes two products, one division,
//   one evaluation and the S_TEST state. One request is processed at a time;
//   s_tready is high only while idle.
//   Reset (aresetn low, synchronous) returns the control to idle, drops any
//   pending result and restores register reset values.
//   A stalled receiver holds the result on m_tdata; the next request is taken
//   once the result is accepted.
`timescale 1ns / 1ps
module false_position_root_finder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // lower_bound[47:0], upper_bound[95:48]
    input  logic [95:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // root[47:0], status[49:48], steps_used[56:50], zero fill
    output logic [63:0]                      m_tdata,
    input  logic                             cfg_we,
    input  logic [fprf_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [fprf_pkg::CFG_W-1:0]       cfg_data
);
    import fprf_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [47:0] csq_reg, clin_reg, ccon_reg;
    logic [32:0] tol_reg;

    logic [63:0] le_reg, le_next, re_reg, re_next;
    logic [63:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [63:0] x_reg, x_next, t_reg, t_next;
    logic [47:0] c_reg, c_next;
    logic [6:0]  steps_reg, steps_next;
    logic        side_reg, side_next;   // 0: eval fa, 1: eval fb (initial), also pass
    logic        init_reg, init_next;
    logic [127:0] p1_reg, p1_next;
    status_t     status_reg, status_next;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b;
    logic [127:0] mul_p;
    logic        div_start, div_done;
    logic [127:0] div_num, div_q;
    logic [63:0] div_dm;

    logic [127:0] numer;
    logic        nneg, dneg;
    logic [63:0] fc;
    logic [63:0] fc_mag;
    logic        br_ac;
    logic [47:0] qsat;

    fprf_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
    );

    fprf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .dm(div_dm), .done(div_done), .quot(div_q)
    );

    function automatic logic brk(input logic [63:0] x, input logic [63:0] y);
        logic xle, xge, yle, yge;
        xle = x[63] || x == '0;
        xge = !x[63];
        yle = y[63] || y == '0;
        yge = !y[63];
        brk = (xle && yge) || (xge && yle);
    endfunction

    assign numer = p1_reg - mul_p;
    assign nneg = numer[127];
    assign dneg = $signed(fa_reg) < $signed(fb_reg);
    assign fc = sat_add64(sat_shift(mul_p), {{16{ccon_reg[47]}}, ccon_reg});
    assign fc_mag = fc[63] ? 64'd0 - fc : fc;
    assign br_ac = brk(fa_reg, fc);

    always_comb begin
        if (nneg != dneg) begin
            qsat = (div_q[127:64] != '0 || div_q[63:0] > 64'h0000_8000_0000_0000)
                   ? ROOT_MIN : 48'(64'd0 - div_q[63:0]);
        end else begin
            qsat = (div_q[127:64] != '0 || div_q[63:0] > 64'h0000_7FFF_FFFF_FFFF)
                   ? ROOT_MAX : div_q[47:0];
        end
    end

    // register port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csq_reg <= COEF_SQUARE_RST;
            clin_reg <= COEF_LINEAR_RST;
            ccon_reg <= COEF_CONST_RST;
            tol_reg <= TOLERANCE_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_COEF_SQUARE: csq_reg <= cfg_data;
                REG_COEF_LINEAR: clin_reg <= cfg_data;
                REG_COEF_CONST:  ccon_reg <= cfg_data;
                REG_TOLERANCE:   tol_reg <= cfg_data[32:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_EVAL_A1;
            S_EVAL_A1:   if (mul_done) state_next = S_EVAL_A2;
            S_EVAL_A2:   if (mul_done) state_next = S_EVAL_DONE;
            S_EVAL_DONE: state_next = init_reg ? (side_reg ? S_CHECK : S_EVAL_A1) : S_TEST;
            S_CHECK:     state_next = brk(fa_reg, fb_reg) ? S_NUM1 : S_OUT;
            S_NUM1: begin
                if (steps_reg == 7'(MAX_STEPS) || fa_reg == fb_reg) begin
                    state_next = S_OUT;
                end else if (mul_done) begin
                    state_next = S_NUM2;
                end
            end
            S_NUM2:      if (mul_done) state_next = S_DIV;
            S_DIV:       state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_done) state_next = S_EVAL_A1;
            S_TEST:      state_next = (fc_mag < {31'd0, tol_reg}) ? S_OUT : S_NUM1;
            S_OUT:       if (m_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        le_next = le_reg; re_next = re_reg; fa_next = fa_reg; fb_next = fb_reg;
        x_next = x_reg; t_next = t_reg; c_next = c_reg;
        steps_next = steps_reg; side_next = side_reg; init_next = init_reg;
        p1_next = p1_reg; status_next = status_reg;
        mul_start = 1'b0; mul_a = '0; mul_b = '0;
        div_start = 1'b0;
        div_num = nneg ? 128'd0 - numer : numer;
        div_dm = dneg ? fb_reg - fa_reg : fa_reg - fb_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    le_next = {{16{s_tdata[47]}}, s_tdata[47:0]};
                    re_next = {{16{s_tdata[95]}}, s_tdata[95:48]};
                    c_next = s_tdata[47:0];
                    x_next = {{16{s_tdata[47]}}, s_tdata[47:0]};
                    steps_next = '0;
                    side_next = 1'b0;
                    init_next = 1'b1;
                    status_next = ST_STEP_LIMIT;
                end
            end
            S_EVAL_A1: begin
                mul_start = 1'b1;
                mul_a = {{16{csq_reg[47]}}, csq_reg};
                mul_b = x_reg;
                if (mul_done) t_next = sat_add64(sat_shift(mul_p), {{16{clin_reg[47]}}, clin_reg});
            end
            S_EVAL_A2: begin
                mul_start = 1'b1;
                mul_a = t_reg;
                mul_b = x_reg;
                if (mul_done) t_next = fc;
            end
            S_EVAL_DONE: begin
                if (init_reg) begin
                    if (!side_reg) begin
                        fa_next = t_reg;
                        side_next = 1'b1;
                        x_next = re_reg;
                    end else begin
                        fb_next = t_reg;
                        init_next = 1'b0;
                    end
                end
            end
            S_CHECK: begin
                if (!brk(fa_reg, fb_reg)) begin
                    c_next = '0;
                    status_next = ST_NO_CHANGE;
                end
            end
            S_NUM1: begin
                if (steps_reg == 7'(MAX_STEPS)) begin
                    status_next = ST_STEP_LIMIT;
                end else if (fa_reg == fb_reg) begin
                    status_next = ST_ZERO_DIV;
                end else begin
                    mul_start = 1'b1;
                    mul_a = re_reg;
                    mul_b = fa_reg;
                    if (mul_done) p1_next = mul_p;
                end
            end
            S_NUM2: begin
                mul_start = 1'b1;
                mul_a = le_reg;
                mul_b = fb_reg;
            end
            S_DIV: begin
                div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    c_next = qsat;
                    x_next = {{16{qsat[47]}}, qsat};
                    steps_next = steps_reg + 7'd1;
                end
            end
            S_TEST: begin
                if (fc_mag < {31'd0, tol_reg}) begin
                    status_next = ST_CONVERGED;
                end else if (br_ac) begin
                    re_next = x_reg;
                    fb_next = t_reg;
                end else begin
                    le_next = x_reg;
                    fa_next = t_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        le_reg <= le_next; re_reg <= re_next; fa_reg <= fa_next; fb_reg <= fb_next;
        x_reg <= x_next; t_reg <= t_next; c_reg <= c_next;
        steps_reg <= steps_next; side_reg <= side_next; init_reg <= init_next;
        p1_reg <= p1_next; status_reg <= status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {7'd0, steps_reg, status_reg, c_reg};
endmodule

// ===== hdl/fprf_mul.sv =====
// Bit-serial signed 64x64 multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module fprf_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] product
);
    import fprf_pkg::*;

    mul_state_t  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] mplier_reg, mplier_next;
    logic [127:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [64:0] sum;

    assign sum = {1'b0, acc_reg[127:64]} + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MUL_IDLE: if (start) state_next = MUL_RUN;
            MUL_RUN:  if (cnt_reg == 7'd63) state_next = MUL_DONE;
            MUL_DONE: state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        case (state_reg)
            MUL_IDLE: begin
                if (start) begin
                    mcand_next = op_a[63] ? 64'd0 - op_a : op_a;
                    mplier_next = op_b[63] ? 64'd0 - op_b : op_b;
                    neg_next = op_a[63] ^ op_b[63];
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            MUL_RUN: begin
                acc_next = {sum, acc_reg[63:1]};
                mplier_next = {1'b0, mplier_reg[63:1]};
                cnt_next = cnt_reg + 7'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
    end

    assign done = (state_reg == MUL_DONE);
    assign product = neg_reg ? 128'd0 - acc_reg : acc_reg;
endmodule

// ===== hdl/fprf_div.sv =====
// Restoring divider: 128-bit magnitude by 64-bit magnitude, one quotient bit per cycle.
`timescale 1ns / 1ps
module fprf_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  dm,
    output logic         done,
    output logic [127:0] quot
);
    import fprf_pkg::*;

    div_state_t   state_reg, state_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [127:0] q_reg, q_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  dm_reg, dm_next;
    logic [64:0]  trial;
    logic         take;

    assign trial = {rem_reg, q_reg[127]};
    assign take = (trial >= {1'b0, dm_reg});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == 8'd127) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        dm_next = dm_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    q_next = num;
                    rem_next = '0;
                    dm_next = dm;
                    cnt_next = '0;
                end
            end
            DIV_RUN: begin
                rem_next = take ? 64'(trial - {1'b0, dm_reg}) : trial[63:0];
                q_next = {q_reg[126:0], take};
                cnt_next = cnt_reg + 8'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        dm_reg <= dm_next;
    end

    assign done = (state_reg == DIV_DONE);
    assign quot = q_reg;
endmodule

// ===== tb/false_position_root_finder_test.sv =====
// Testbench for the false-position root finder: scoreboard plus stimulus over several register settings.
`timescale 1ns / 1ps
module false_position_root_finder_test;
    import fprf_pkg::*;

    typedef struct {
        logic [47:0] root;
        status_t     status;
        logic [6:0]  steps;
    } root_result_t;

    class root_board;
        longint      a_sq, b_lin, c_const;
        logic [32:0] tol;
        root_result_t pending_q[$];
        int errors;
        int seen;
        int per_status[4];

        function new();
            a_sq = longint'($signed(COEF_SQUARE_RST));
            b_lin = longint'($signed(COEF_LINEAR_RST));
            c_const = longint'($signed(COEF_CONST_RST));
            tol = TOLERANCE_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_COEF_SQUARE: a_sq = longint'($signed(val));
                REG_COEF_LINEAR: b_lin = longint'($signed(val));
                REG_COEF_CONST: c_const = longint'($signed(val));
                REG_TOLERANCE: tol = val[32:0];
                default: ;
            endcase
        endfunction

        function longint clamp63(logic signed [129:0] v);
            logic signed [129:0] lim;
            lim = 130'sh7FFF_FFFF_FFFF_FFFF;
            if (v > lim) return longint'(lim[63:0]);
            if (v < -lim) return -longint'(lim[63:0]);
            return longint'(v[63:0]);
        endfunction

        function longint mul_shift(longint a, longint b);
            logic signed [129:0] ea, eb, p;
            ea = a;
            eb = b;
            p = (ea * eb) >>> FRAC_BITS;
            return clamp63(p);
        endfunction

        function longint add_sat(longint a, longint b);
            logic signed [129:0] ea, eb;
            ea = a;
            eb = b;
            return clamp63(ea + eb);
        endfunction

        function longint eval_poly(longint x);
            longint t;
            t = mul_shift(a_sq, x);
            t = add_sat(t, b_lin);
            t = mul_shift(t, x);
            return add_sat(t, c_const);
        endfunction

        function bit straddles(longint fx, longint fy);
            return (fx <= 0 && fy >= 0) || (fx >= 0 && fy <= 0);
        endfunction

        function longint secant_point(longint a, longint b, longint fa, longint fb);
            logic signed [129:0] ea, eb, efa, efb, q;
            ea = a;
            eb = b;
            efa = fa;
            efb = fb;
            q = (eb * efa - ea * efb) / (efa - efb);
            if (q > 130'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
            if (q < -130'sh8000_0000_0000) return -64'sh8000_0000_0000;
            return longint'(q[63:0]);
        endfunction

        function void note_request(logic [47:0] lo, logic [47:0] hi);
            longint l, r, fa, fb, fc, c;
            int n;
            root_result_t e;
            logic [63:0] mag;
            l = longint'($signed(lo));
            r = longint'($signed(hi));
            fa = eval_poly(l);
            fb = eval_poly(r);
            n = 0;
            if (!straddles(fa, fb)) begin
                e.root = '0;
                e.status = ST_NO_CHANGE;
                e.steps = '0;
            end else begin
                c = l;
                e.status = ST_STEP_LIMIT;
                while (n < MAX_STEPS) begin
                    if (fa == fb) begin
                        e.status = ST_ZERO_DIV;
                        break;
                    end
                    c = secant_point(l, r, fa, fb);
                    n++;
                    fc = eval_poly(c);
                    mag = fc < 0 ? -fc : fc;
                    if (mag < {31'b0, tol}) begin
                        e.status = ST_CONVERGED;
                        break;
                    end
                    if (straddles(fa, fc)) begin
                        r = c;
                        fb = fc;
                    end else begin
                        l = c;
                        fa = fc;
                    end
                end
                e.root = c[47:0];
                e.steps = n[6:0];
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [63:0] d);
            root_result_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            seen++;
            per_status[e.status]++;
            if (d[47:0] !== e.root) begin
                $error("root expected %h actual %h", e.root, d[47:0]);
                errors++;
            end
            if (d[49:48] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, d[49:48]);
                errors++;
            end
            if (d[56:50] !== e.steps) begin
                $error("steps_used expected %0d actual %0d", e.steps, d[56:50]);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    root_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    false_position_root_finder uut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [47:0] q_val(int whole);
        longint v;
        v = longint'(whole) <<< FRAC_BITS;
        return v[47:0];
    endfunction

    // random value in [lo_whole, hi_whole + 2^-16) with random fraction
    function automatic logic [47:0] q_rand(int lo_whole, int hi_whole);
        longint v;
        v = (longint'($urandom_range(0, (hi_whole - lo_whole) * 65536)) +
             longint'(lo_whole) * 65536) <<< 16;
        v = v | longint'($urandom_range(0, 65535));
        return v[47:0];
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_bracket(logic [47:0] lo, logic [47:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        board.note_request(lo, hi);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic set_coefs(logic [47:0] a, logic [47:0] b, logic [47:0] c);
        write_reg(REG_COEF_SQUARE, a);
        write_reg(REG_COEF_LINEAR, b);
        write_reg(REG_COEF_CONST, c);
        @(posedge aclk);
    endtask

    task automatic set_idle(int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 47; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 47; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    // brackets around roots 2 and 3 of the reset polynomial, plus noise
    task automatic random_items(int count);
        int k;
        for (k = 0; k < count; k++) begin
            set_idle(k / 9);
            case ($urandom_range(9))
                0, 1, 2: send_bracket(q_rand(-6, 1), q_rand(2, 2) | 48'h0000_4000_0000);
                3, 4, 5: send_bracket(q_rand(2, 2) | 48'h0000_4000_0000, q_rand(3, 9));
                6: send_bracket(q_rand(-9, 9), q_rand(-9, 9));
                7: send_bracket(~rand48() & rand48(), rand48() | rand48());
                default: send_bracket(rand48(), rand48());
            endcase
        end
    endtask

    initial begin
        #300ms;
        $display("false_position_root_finder_test failed");
        $finish;
    end

    initial begin
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed, reset coefficients
        send_bracket(q_val(0), q_val(2) | 48'h0000_8000_0000);
        send_bracket(q_val(2) | 48'h0000_8000_0000, q_val(10));
        send_bracket(q_val(0), q_val(1));
        send_bracket(q_val(2), q_val(3));
        send_bracket(q_val(1), q_val(2));
        send_bracket(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_bracket(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_bracket(48'h0, 48'h0);
        send_bracket(48'hFFFF_FFFF_FFFF, q_val(2) | 48'h0000_0000_0001);
        drain();

        // zero tolerance, no convergence possible: step limit; then a tolerance of 1.0
        write_reg(REG_TOLERANCE, CFG_W'(33'd0));
        send_bracket(q_val(0), q_val(2) | 48'h0000_8000_0000);
        send_bracket(q_val(-7), q_val(2) | 48'h0000_C000_0000);
        drain();
        write_reg(REG_TOLERANCE, CFG_W'(33'h1_0000_0000));
        send_bracket(q_val(0), q_val(2) | 48'h0000_8000_0000);
        send_bracket(q_val(-3), q_val(10));
        drain();

        // extreme coefficients, a flat polynomial for zero divisor and a linear one
        set_coefs(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_bracket(q_val(-1), q_val(1));
        send_bracket(48'h8000_0000_0000, 48'h0000_0000_0001);
        send_bracket(q_val(0), q_val(3));
        drain();
        set_coefs(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_bracket(q_val(-1), q_val(1));
        send_bracket(q_val(0), 48'h7FFF_FFFF_FFFF);
        drain();
        set_coefs(48'h0, 48'h0, 48'h0);
        send_bracket(q_val(-4), q_val(4));
        drain();
        set_coefs(48'h0, q_val(1), q_val(-1));
        send_bracket(q_val(-4), q_val(4));
        send_bracket(q_val(-9000), q_val(9000));
        drain();

        // back to reset polynomial, random tolerance
        set_coefs(COEF_SQUARE_RST, COEF_LINEAR_RST, COEF_CONST_RST);
        write_reg(REG_TOLERANCE, CFG_W'({1'b0, $urandom} & 33'h0_000F_FFFF));
        random_items(60);

        // receiver holds off while the sender keeps offering
        hold_left = 40000;
        set_idle(0);
        for (k = 0; k < 4; k++) send_bracket(q_rand(-6, 1), q_val(2) | 48'h0000_8000_0000);
        drain();

        write_reg(REG_TOLERANCE, CFG_W'(TOLERANCE_RST));
        random_items(25);
        drain();

        // random coefficients
        for (k = 0; k < 3; k++) begin
            set_coefs(q_rand(-4, 4), q_rand(-8, 8), q_rand(-8, 8));
            write_reg(REG_TOLERANCE, CFG_W'({1'b0, $urandom_range(1, 1 << 24)}));
            set_idle(k + 1);
            repeat (10) send_bracket(q_rand(-9, 9), q_rand(-9, 9));
            drain();
        end

        repeat (200) @(posedge aclk);
        $display("checked %0d results under several register sets and idle patterns",
                 board.seen);
        $display("%0d converged, %0d no sign change, %0d step limit, %0d zero divisor",
                 board.per_status[0], board.per_status[1],
                 board.per_status[2], board.per_status[3]);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("false_position_root_finder_test passed");
        end else begin
            $display("false_position_root_finder_test failed");
        end
        $finish;
    end
endmodule
